@@ rtl/core/fcpr_pkg.sv @@
// Fan curve controller package: register indexes, curve table and types.
package fcpr_pkg;

    localparam int unsigned CfgIndexWidth = 3;
    localparam int unsigned CfgDataWidth  = 16;

    localparam logic [CfgIndexWidth-1:0] REG_CURVE_SELECT = 3'd0;
    localparam logic [CfgIndexWidth-1:0] REG_MIN_DUTY     = 3'd1;
    localparam logic [CfgIndexWidth-1:0] REG_MAX_DUTY     = 3'd2;
    localparam logic [CfgIndexWidth-1:0] REG_SPINUP_TICKS = 3'd3;
    localparam logic [CfgIndexWidth-1:0] REG_SPINUP_DUTY  = 3'd4;
    localparam logic [CfgIndexWidth-1:0] REG_RAMP_DELAY   = 3'd5;
    localparam logic [CfgIndexWidth-1:0] REG_INITIAL_DUTY = 3'd6;

    localparam logic [8:0] HOLD_BAND   = 9'd2;
    localparam logic [6:0] HOLD_LIMIT  = 7'd100;
    localparam logic [6:0] INVERT_BASE = 7'd100;

    typedef struct packed {
        logic [7:0]         tmin;
        logic [7:0]         tmax;
        logic [12:0]        slope;
        logic signed [18:0] offset;
    } curve_t;

    function automatic curve_t curve_entry(input logic [3:0] sel);
        curve_t c;
        case (sel)
            4'd0:    c = '{8'd20, 8'd40, 13'd1024, -19'sd15360};
            4'd1:    c = '{8'd25, 8'd40, 13'd1364, -19'sd29012};
            4'd2:    c = '{8'd30, 8'd40, 13'd2048, -19'sd56320};
            4'd3:    c = '{8'd35, 8'd40, 13'd4096, -19'sd138240};
            4'd4:    c = '{8'd20, 8'd50, 13'd681,  -19'sd8532};
            4'd5:    c = '{8'd30, 8'd50, 13'd1024, -19'sd25600};
            4'd6:    c = '{8'd35, 8'd50, 13'd1364, -19'sd42668};
            4'd7:    c = '{8'd40, 8'd50, 13'd2048, -19'sd76800};
            4'd8:    c = '{8'd20, 8'd60, 13'd512,  -19'sd5120};
            4'd9:    c = '{8'd30, 8'd60, 13'd681,  -19'sd15360};
            4'd10:   c = '{8'd40, 8'd60, 13'd1024, -19'sd35840};
            4'd11:   c = '{8'd50, 8'd60, 13'd2048, -19'sd97280};
            4'd12:   c = '{8'd20, 8'd70, 13'd410,  -19'sd3072};
            4'd13:   c = '{8'd35, 8'd70, 13'd584,  -19'sd15360};
            4'd14:   c = '{8'd45, 8'd70, 13'd819,  -19'sd31744};
            default: c = '{8'd55, 8'd70, 13'd1364, -19'sd69972};
        endcase
        return c;
    endfunction

endpackage

@@ rtl/core/fan_curve_pwm_ramp_controller_core.sv @@
// Fan curve, spin-up hold and PWM ramp controller, top level.
// Result: an accepted request's result is registered in the output register, visible the cycle after acceptance.
// Throughput: one request per cycle while no result is pending or the pending one is
// taken; the single result register is refilled in the cycle it is taken.
// Reset: asynchronous, active low; configuration and state registers take their reset
// values, ramp duty starts at the initial duty (30), no result pending; result data is not reset.
module fan_curve_pwm_ramp_controller_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [fcpr_pkg::CfgIndexWidth-1:0] cfg_index,
    input  logic [fcpr_pkg::CfgDataWidth-1:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  temp_outlet_a,
    input  logic [7:0]  temp_outlet_b,
    input  logic [7:0]  temp_outlet_c,
    input  logic        fan_failed,
    input  logic        sensor_failed,
    input  logic        force_full,
    input  logic        power_good,
    input  logic        remote_mode,
    input  logic [7:0]  remote_duty,
    input  logic        spinup_request,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [6:0]  duty_percent,
    output logic [6:0]  compare_value,
    output logic [7:0]  curve_target,
    output logic [7:0]  held_temp
);

    // configuration
    logic [3:0]  curve_select_reg;
    logic [6:0]  min_duty_reg;
    logic [6:0]  max_duty_reg;
    logic [15:0] spinup_ticks_reg;
    logic [6:0]  spinup_duty_reg;
    logic [15:0] ramp_delay_reg;

    // state
    logic [7:0]  held_temperature_reg, held_temperature_next;
    logic [6:0]  hold_counter_reg, hold_counter_next;
    logic [15:0] spinup_counter_reg, spinup_counter_next;
    logic [15:0] ramp_counter_reg, ramp_counter_next;
    logic [6:0]  ramp_duty_reg, ramp_duty_next;

    // result register
    logic        out_valid_reg;
    logic [6:0]  duty_percent_reg, duty_percent_next;
    logic [6:0]  compare_value_reg, compare_value_next;
    logic [7:0]  curve_target_reg, curve_target_next;
    logic [7:0]  held_temp_reg;

    logic        accept;
    logic [7:0]  hottest;
    logic [7:0]  curve_duty;
    logic [7:0]  target;
    logic [15:0] spin_base;
    logic [7:0]  ramp_raw;
    logic [7:0]  ramp_min;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    fcpr_curve u_curve (
        .curve_select (curve_select_reg),
        .temp         (held_temperature_next),
        .min_duty     (min_duty_reg),
        .max_duty     (max_duty_reg),
        .duty         (curve_duty)
    );

    always_comb
    begin
        hottest = temp_outlet_a;
        if (temp_outlet_b > hottest)
        begin
            hottest = temp_outlet_b;
        end
        if (temp_outlet_c > hottest)
        begin
            hottest = temp_outlet_c;
        end

        held_temperature_next = held_temperature_reg;
        if (({1'b0, hottest} + fcpr_pkg::HOLD_BAND < {1'b0, held_temperature_reg}) ||
            ({1'b0, hottest} > {1'b0, held_temperature_reg} + fcpr_pkg::HOLD_BAND))
        begin
            held_temperature_next = hottest;
        end
        if (hold_counter_reg > fcpr_pkg::HOLD_LIMIT)
        begin
            hold_counter_next     = 7'd0;
            held_temperature_next = hottest;
        end
        else
        begin
            hold_counter_next = hold_counter_reg + 7'd1;
        end

        if (fan_failed || sensor_failed || force_full)
        begin
            curve_target_next = power_good ? {1'b0, max_duty_reg} : {1'b0, min_duty_reg};
        end
        else
        begin
            curve_target_next = curve_duty;
        end

        target    = remote_mode ? remote_duty : curve_target_next;
        spin_base = spinup_request ? 16'd0 : spinup_counter_reg;

        spinup_counter_next = spin_base;
        ramp_counter_next   = ramp_counter_reg;
        ramp_raw            = {1'b0, ramp_duty_reg};
        if (spin_base < spinup_ticks_reg)
        begin
            spinup_counter_next = spin_base + 16'd1;
            ramp_raw            = {1'b0, spinup_duty_reg};
        end
        else if (ramp_counter_reg < ramp_delay_reg)
        begin
            ramp_counter_next = ramp_counter_reg + 16'd1;
        end
        else
        begin
            ramp_counter_next = 16'd0;
            if ({1'b0, ramp_duty_reg} < target)
            begin
                ramp_raw = {1'b0, ramp_duty_reg} + 8'd1;
            end
            else if ({1'b0, ramp_duty_reg} > target)
            begin
                ramp_raw = {1'b0, ramp_duty_reg} - 8'd1;
            end
        end

        ramp_min = (ramp_raw < {1'b0, min_duty_reg}) ? {1'b0, min_duty_reg} : ramp_raw;
        ramp_duty_next = (ramp_min > {1'b0, max_duty_reg}) ? max_duty_reg : ramp_min[6:0];

        duty_percent_next = ramp_duty_next;
        if (ramp_duty_next >= fcpr_pkg::INVERT_BASE)
        begin
            compare_value_next = ramp_duty_next - fcpr_pkg::INVERT_BASE;
        end
        else
        begin
            compare_value_next = fcpr_pkg::INVERT_BASE - ramp_duty_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_select_reg     <= 4'd0;
            min_duty_reg         <= 7'd20;
            max_duty_reg         <= 7'd100;
            spinup_ticks_reg     <= 16'd30;
            spinup_duty_reg      <= 7'd100;
            ramp_delay_reg       <= 16'd1;
            held_temperature_reg <= 8'd0;
            hold_counter_reg     <= 7'd0;
            spinup_counter_reg   <= 16'd0;
            ramp_counter_reg     <= 16'd0;
            ramp_duty_reg        <= 7'd30;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    fcpr_pkg::REG_CURVE_SELECT: curve_select_reg <= cfg_data[3:0];
                    fcpr_pkg::REG_MIN_DUTY:     min_duty_reg     <= cfg_data[6:0];
                    fcpr_pkg::REG_MAX_DUTY:     max_duty_reg     <= cfg_data[6:0];
                    fcpr_pkg::REG_SPINUP_TICKS: spinup_ticks_reg <= cfg_data;
                    fcpr_pkg::REG_SPINUP_DUTY:  spinup_duty_reg  <= cfg_data[6:0];
                    fcpr_pkg::REG_RAMP_DELAY:   ramp_delay_reg   <= cfg_data;
                    fcpr_pkg::REG_INITIAL_DUTY: ramp_duty_reg    <= cfg_data[6:0];
                    default: ;
                endcase
            end
            else if (accept)
            begin
                ramp_duty_reg <= ramp_duty_next;
            end

            if (accept)
            begin
                held_temperature_reg <= held_temperature_next;
                hold_counter_reg     <= hold_counter_next;
                spinup_counter_reg   <= spinup_counter_next;
                ramp_counter_reg     <= ramp_counter_next;
                out_valid_reg        <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            duty_percent_reg  <= duty_percent_next;
            compare_value_reg <= compare_value_next;
            curve_target_reg  <= curve_target_next;
            held_temp_reg     <= held_temperature_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign duty_percent  = duty_percent_reg;
    assign compare_value = compare_value_reg;
    assign curve_target  = curve_target_reg;
    assign held_temp     = held_temp_reg;

    a_hold_counter_range: assert property (@(posedge clk) disable iff (!rst_n)
        hold_counter_reg <= fcpr_pkg::HOLD_LIMIT + 7'd1)
        else $error("hold counter out of range");

    a_duty_within_max: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> duty_percent_reg <= max_duty_reg)
        else $error("duty above maximum");

    a_compare_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && duty_percent_reg <= fcpr_pkg::INVERT_BASE) |->
        (duty_percent_reg + compare_value_reg == fcpr_pkg::INVERT_BASE))
        else $error("compare value does not invert duty");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !(out_valid_reg && !out_ready))
        else $error("request accepted over a pending result");

    a_spinup_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && spinup_request && spinup_ticks_reg != 16'd0 && !cfg_wr_en) |=>
        spinup_counter_reg == 16'd1)
        else $error("spin-up request did not restart hold");

endmodule

@@ rtl/core/fcpr_curve.sv @@
// Temperature to duty curve evaluation, one multiply and add.
module fcpr_curve (
    input  logic [3:0] curve_select,
    input  logic [7:0] temp,
    input  logic [6:0] min_duty,
    input  logic [6:0] max_duty,
    output logic [7:0] duty
);

    fcpr_pkg::curve_t   c;
    logic signed [13:0] slope_s;
    logic signed [8:0]  temp_s;
    logic signed [22:0] prod;
    logic signed [22:0] sum;

    always_comb
    begin
        c       = fcpr_pkg::curve_entry(curve_select);
        slope_s = $signed({1'b0, c.slope});
        temp_s  = $signed({1'b0, temp});
        prod    = slope_s * temp_s;
        sum     = prod + $signed({{4{c.offset[18]}}, c.offset});
        if (temp <= c.tmin)
        begin
            duty = {1'b0, min_duty};
        end
        else if (temp >= c.tmax)
        begin
            duty = {1'b0, max_duty};
        end
        else if (sum[22])
        begin
            duty = 8'd0;
        end
        else if (sum[21:16] != 6'd0)
        begin
            duty = 8'd255;
        end
        else
        begin
            duty = sum[15:8];
        end
    end

endmodule

@@ verif/fan_curve_pwm_ramp_controller_core_test.sv @@
// Self-checking testbench for the fan curve and PWM ramp controller core.
module fan_curve_pwm_ramp_controller_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [fcpr_pkg::CfgIndexWidth-1:0] REG_UNUSED = 3'd7;
    localparam int BAND        = 2;
    localparam int HOLD_WRAP   = 100;
    localparam int DUTY_FULL   = 100;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASES      = 17;
    localparam int PHASE_TICKS = 100;

    localparam int CURVE_TMIN [16] = '{20, 25, 30, 35, 20, 30, 35, 40,
                                       20, 30, 40, 50, 20, 35, 45, 55};
    localparam int CURVE_TMAX [16] = '{40, 40, 40, 40, 50, 50, 50, 50,
                                       60, 60, 60, 60, 70, 70, 70, 70};
    localparam int CURVE_SLOPE [16] = '{1024, 1364, 2048, 4096, 681, 1024, 1364, 2048,
                                        512, 681, 1024, 2048, 410, 584, 819, 1364};
    localparam int CURVE_OFFSET [16] = '{-15360, -29012, -56320, -138240,
                                         -8532, -25600, -42668, -76800,
                                         -5120, -15360, -35840, -97280,
                                         -3072, -15360, -31744, -69972};

    typedef struct packed {
        logic [7:0] temp_a;
        logic [7:0] temp_b;
        logic [7:0] temp_c;
        logic       fan_err;
        logic       sensor_fail;
        logic       force_max;
        logic       pwr_good;
        logic       remote_sel;
        logic [7:0] remote_pct;
        logic       spin_req;
    } tick_request_t;

    typedef struct packed {
        logic [6:0] duty;
        logic [6:0] compare;
        logic [7:0] curve;
        logic [7:0] held;
    } tick_result_t;

    class duty_scoreboard;
        bit [3:0]  curve_sel;
        bit [6:0]  min_pct;
        bit [6:0]  max_pct;
        bit [6:0]  spin_pct;
        bit [6:0]  start_pct;
        bit [15:0] spin_len;
        bit [15:0] step_wait;
        bit [7:0]  held_t;
        bit [6:0]  hold_ticks;
        bit [7:0]  curve_pct;
        bit [15:0] spin_cnt;
        bit [15:0] step_cnt;
        bit [7:0]  ramp_pct;
        tick_result_t due_q[$];
        int errors;
        int checked;

        function new();
            curve_sel  = 0;
            min_pct    = 20;
            max_pct    = 100;
            spin_len   = 30;
            spin_pct   = 100;
            step_wait  = 1;
            start_pct  = 30;
            held_t     = 0;
            hold_ticks = 0;
            curve_pct  = 20;
            spin_cnt   = 0;
            step_cnt   = 0;
            ramp_pct   = 30;
            errors     = 0;
            checked    = 0;
        endfunction

        function void write_reg(logic [fcpr_pkg::CfgIndexWidth-1:0] idx, logic [15:0] val);
            case (idx)
                fcpr_pkg::REG_CURVE_SELECT: curve_sel = val[3:0];
                fcpr_pkg::REG_MIN_DUTY:     min_pct   = val[6:0];
                fcpr_pkg::REG_MAX_DUTY:     max_pct   = val[6:0];
                fcpr_pkg::REG_SPINUP_TICKS: spin_len  = val;
                fcpr_pkg::REG_SPINUP_DUTY:  spin_pct  = val[6:0];
                fcpr_pkg::REG_RAMP_DELAY:   step_wait = val;
                fcpr_pkg::REG_INITIAL_DUTY:
                begin
                    start_pct = val[6:0];
                    ramp_pct  = {1'b0, val[6:0]};
                end
                default: ;
            endcase
        endfunction

        function bit [7:0] curve_lookup(bit [7:0] t);
            int s;
            if (t <= CURVE_TMIN[curve_sel])
                return {1'b0, min_pct};
            if (t >= CURVE_TMAX[curve_sel])
                return {1'b0, max_pct};
            s = CURVE_SLOPE[curve_sel] * int'(t) + CURVE_OFFSET[curve_sel];
            if (s < 0)
                return 8'd0;
            s = s / 256;
            if (s > 255)
                return 8'd255;
            return s[7:0];
        endfunction

        function void note_request(tick_request_t r);
            bit [7:0] hot;
            bit [7:0] goal;
            int inv_pct;
            tick_result_t e;
            hot = r.temp_a;
            if (r.temp_b > hot)
                hot = r.temp_b;
            if (r.temp_c > hot)
                hot = r.temp_c;
            if (int'(hot) < int'(held_t) - BAND || int'(hot) > int'(held_t) + BAND)
                held_t = hot;
            if (hold_ticks > HOLD_WRAP)
            begin
                hold_ticks = 0;
                held_t = hot;
            end
            else
                hold_ticks++;

            if (r.fan_err || r.sensor_fail || r.force_max)
                curve_pct = r.pwr_good ? {1'b0, max_pct} : {1'b0, min_pct};
            else
                curve_pct = curve_lookup(held_t);

            if (r.spin_req)
                spin_cnt = 0;
            goal = r.remote_sel ? r.remote_pct : curve_pct;

            if (spin_cnt < spin_len)
            begin
                spin_cnt++;
                ramp_pct = {1'b0, spin_pct};
            end
            else if (step_cnt < step_wait)
                step_cnt++;
            else
            begin
                step_cnt = 0;
                if (ramp_pct < goal)
                    ramp_pct++;
                else if (ramp_pct > goal)
                    ramp_pct--;
            end
            if (ramp_pct < min_pct)
                ramp_pct = {1'b0, min_pct};
            if (ramp_pct > max_pct)
                ramp_pct = {1'b0, max_pct};

            inv_pct = int'(ramp_pct) - DUTY_FULL;
            if (inv_pct < 0)
                inv_pct = -inv_pct;
            e.duty    = ramp_pct[6:0];
            e.compare = inv_pct[6:0];
            e.curve   = curve_pct;
            e.held    = held_t;
            due_q.push_back(e);
        endfunction

        function void field_check(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(tick_result_t a);
            tick_result_t e;
            if (due_q.size() == 0)
            begin
                errors++;
                $display("%0t: result with no request waiting: duty %0d compare %0d",
                         $time, a.duty, a.compare);
                $display("%0t: unexpected result continued: curve %0d held %0d",
                         $time, a.curve, a.held);
                return;
            end
            e = due_q.pop_front();
            checked++;
            field_check("duty_percent", {1'b0, e.duty}, {1'b0, a.duty});
            field_check("compare_value", {1'b0, e.compare}, {1'b0, a.compare});
            field_check("curve_target", e.curve, a.curve);
            field_check("held_temp", e.held, a.held);
        endfunction
    endclass

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_wr_en;
    logic [fcpr_pkg::CfgIndexWidth-1:0] cfg_index;
    logic [fcpr_pkg::CfgDataWidth-1:0]  cfg_data;
    logic                               in_valid;
    logic                               in_ready;
    logic [7:0]                         temp_outlet_a;
    logic [7:0]                         temp_outlet_b;
    logic [7:0]                         temp_outlet_c;
    logic                               fan_failed;
    logic                               sensor_failed;
    logic                               force_full;
    logic                               power_good;
    logic                               remote_mode;
    logic [7:0]                         remote_duty;
    logic                               spinup_request;
    logic                               out_valid;
    logic                               out_ready;
    logic [6:0]                         duty_percent;
    logic [6:0]                         compare_value;
    logic [7:0]                         curve_target;
    logic [7:0]                         held_temp;

    duty_scoreboard sb = new();
    bit tx_idle = 1'b0;
    bit rx_idle = 1'b0;
    int rx_hold = 0;
    int drift_t = 30;
    int sent = 0;

    fan_curve_pwm_ramp_controller_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .temp_outlet_a  (temp_outlet_a),
        .temp_outlet_b  (temp_outlet_b),
        .temp_outlet_c  (temp_outlet_c),
        .fan_failed     (fan_failed),
        .sensor_failed  (sensor_failed),
        .force_full     (force_full),
        .power_good     (power_good),
        .remote_mode    (remote_mode),
        .remote_duty    (remote_duty),
        .spinup_request (spinup_request),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .duty_percent   (duty_percent),
        .compare_value  (compare_value),
        .curve_target   (curve_target),
        .held_temp      (held_temp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result(tick_result_t'{duty_percent, compare_value,
                                               curve_target, held_temp});
            if (in_valid && in_ready)
                sb.note_request(tick_request_t'{temp_outlet_a, temp_outlet_b, temp_outlet_c,
                                                fan_failed, sensor_failed, force_full,
                                                power_good, remote_mode, remote_duty,
                                                spinup_request});
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || cfg_wr_en || (in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: timeout, %0d cycles without a request or result", $time, quiet);
        $display("fan_curve_pwm_ramp_controller_core_test NOT OK");
        $finish;
    end

    // result side: random stall bursts, and one long hold-off when rx_hold is set
    initial
    begin : result_sink
        int burst;
        burst = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                out_ready <= 1'b0;
                rx_hold--;
            end
            else if (burst > 0)
            begin
                out_ready <= 1'b0;
                burst--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (rx_idle && $urandom_range(0, 5) == 0)
                    burst = $urandom_range(1, 8);
            end
        end
    end

    task automatic send_tick(input tick_request_t r);
        int gap;
        if (tx_idle && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        temp_outlet_a  <= r.temp_a;
        temp_outlet_b  <= r.temp_b;
        temp_outlet_c  <= r.temp_c;
        fan_failed     <= r.fan_err;
        sensor_failed  <= r.sensor_fail;
        force_full     <= r.force_max;
        power_good     <= r.pwr_good;
        remote_mode    <= r.remote_sel;
        remote_duty    <= r.remote_pct;
        spinup_request <= r.spin_req;
        in_valid       <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.due_q.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic reg_write(input logic [fcpr_pkg::CfgIndexWidth-1:0] idx,
                             input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        sb.write_reg(idx, val);
        @(negedge clk);
    endtask

    // phase 1 zeros (max duty 100), 2 min above max, 4 long spin-up, 5 out of range,
    // 6 longest ramp delay, 7 unused index, 8 raw 16-bit data
    task automatic configure_phase(input int p);
        reg_write(fcpr_pkg::REG_CURVE_SELECT, {12'($urandom_range(0, 4095)), 4'(p)});
        reg_write(fcpr_pkg::REG_MIN_DUTY, p == 1 ? 16'd0 : p == 2 ? 16'd100 :
                  p == 5 ? 16'd127 : p == 8 ? 16'($urandom) : 16'($urandom_range(0, 40)));
        reg_write(fcpr_pkg::REG_MAX_DUTY, p == 1 ? 16'd100 : p == 2 ? 16'd0 :
                  p == 5 ? 16'd127 : p == 8 ? 16'($urandom) : 16'($urandom_range(60, 100)));
        reg_write(fcpr_pkg::REG_SPINUP_TICKS, p == 1 ? 16'd0 : p == 4 ? 16'hFFFF :
                  16'($urandom_range(0, 40)));
        reg_write(fcpr_pkg::REG_SPINUP_DUTY, p == 1 ? 16'd0 : p == 4 ? 16'd127 :
                  p == 8 ? 16'($urandom) : 16'($urandom_range(0, 100)));
        reg_write(fcpr_pkg::REG_RAMP_DELAY, p == 1 ? 16'd0 : p == 6 ? 16'hFFFF :
                  16'($urandom_range(0, 3)));
        if (p == 7)
            reg_write(REG_UNUSED, 16'($urandom));
        reg_write(fcpr_pkg::REG_INITIAL_DUTY, p == 1 ? 16'd0 : p == 5 ? 16'd127 :
                  p == 8 ? 16'($urandom) : 16'($urandom_range(0, 100)));
        cfg_wr_en <= 1'b0;
    endtask

    function automatic tick_request_t temps_tick(int a, int b, int c);
        tick_request_t r;
        r = '0;
        r.temp_a   = a[7:0];
        r.temp_b   = b[7:0];
        r.temp_c   = c[7:0];
        r.pwr_good = 1'b1;
        return r;
    endfunction

    // mostly slowly drifting temperatures around the curve knees
    function automatic tick_request_t random_tick();
        tick_request_t r;
        int k;
        r = '0;
        k = $urandom_range(0, 99);
        if (k < 8)
        begin
            r.temp_a = 8'($urandom_range(0, 255));
            r.temp_b = 8'($urandom_range(0, 255));
            r.temp_c = 8'($urandom_range(0, 255));
        end
        else
        begin
            if (k < 11 || drift_t < 8 || drift_t > 90)
                drift_t = $urandom_range(10, 80);
            else
                drift_t += int'($urandom_range(0, 6)) - 3;
            r.temp_a = 8'(drift_t - int'($urandom_range(0, 3)));
            r.temp_b = 8'(drift_t - int'($urandom_range(0, 3)));
            r.temp_c = 8'(drift_t - int'($urandom_range(0, 3)));
        end
        r.fan_err     = ($urandom_range(0, 24) == 0);
        r.sensor_fail = ($urandom_range(0, 24) == 0);
        r.force_max   = ($urandom_range(0, 24) == 0);
        r.pwr_good    = ($urandom_range(0, 1) != 0);
        r.remote_sel  = ($urandom_range(0, 5) == 0);
        r.remote_pct  = 8'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 110) :
                           $urandom_range(0, 255));
        r.spin_req    = ($urandom_range(0, 59) == 0);
        return r;
    endfunction

    initial
    begin : main_seq
        tick_request_t r;
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        temp_outlet_a  = '0;
        temp_outlet_b  = '0;
        temp_outlet_c  = '0;
        fan_failed     = 1'b0;
        sensor_failed  = 1'b0;
        force_full     = 1'b0;
        power_good     = 1'b0;
        remote_mode    = 1'b0;
        remote_duty    = '0;
        spinup_request = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: band edges, curve knees, fail and override paths
        r = temps_tick(0, 0, 0);
        r.pwr_good = 1'b0;
        send_tick(r);
        r = temps_tick(255, 255, 255);
        r.remote_pct = 8'd255;
        send_tick(r);
        send_tick(temps_tick(30, 10, 5));
        send_tick(temps_tick(10, 32, 5));
        send_tick(temps_tick(5, 10, 33));
        send_tick(temps_tick(31, 0, 0));
        send_tick(temps_tick(30, 30, 0));
        send_tick(temps_tick(20, 20, 20));
        send_tick(temps_tick(21, 0, 0));
        send_tick(temps_tick(0, 39, 0));
        send_tick(temps_tick(0, 0, 40));
        r = temps_tick(25, 25, 25);
        r.fan_err = 1'b1;
        send_tick(r);
        r.pwr_good = 1'b0;
        send_tick(r);
        r = temps_tick(25, 25, 25);
        r.sensor_fail = 1'b1;
        send_tick(r);
        r = temps_tick(25, 25, 25);
        r.force_max = 1'b1;
        r.pwr_good  = 1'b0;
        send_tick(r);
        r = temps_tick(35, 35, 35);
        r.fan_err     = 1'b1;
        r.sensor_fail = 1'b1;
        r.force_max   = 1'b1;
        send_tick(r);
        r = temps_tick(35, 35, 35);
        r.remote_sel = 1'b1;
        send_tick(r);
        r.remote_pct = 8'd255;
        send_tick(r);
        r.remote_pct = 8'h55;
        r.spin_req   = 1'b1;
        send_tick(r);
        r = temps_tick(8'hAA, 8'h55, 8'hFF);
        r.remote_pct = 8'hAA;
        r.spin_req   = 1'b1;
        send_tick(r);
        drain_results();

        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
                configure_phase(p);
            for (int i = 0; i < PHASE_TICKS; i++)
            begin
                if (i % 32 == 0)
                begin
                    tx_idle = (p < PHASES - 2) && ($urandom_range(0, 2) != 0);
                    rx_idle = (p < PHASES - 2) && ($urandom_range(0, 2) != 0);
                end
                if (p == 3 && i == 30)
                    rx_hold = 300;
                send_tick(random_tick());
            end
            drain_results();
        end

        repeat (5) @(posedge clk);
        $display("%0d ticks over %0d register settings: all curves, inverted limits,",
                 sent, PHASES);
        $display("out of range limits, spin-up and ramp delay at both ends;");
        $display("%0d results checked, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("fan_curve_pwm_ramp_controller_core_test OK");
        else
            $display("fan_curve_pwm_ramp_controller_core_test NOT OK");
        $finish;
    end
endmodule
